// ===== rtl/lr0p_pkg.sv =====
// Shared constants, entry layouts and codes of the LR(0) parser engine.
package lr0p_pkg;

    localparam int STATE_BITS    = 8;
    localparam int SYMBOL_BITS   = 7;
    localparam int STACK_DEPTH   = 64;
    localparam int PENDING_DEPTH = 8;

    localparam int TABLE_AW    = STATE_BITS + SYMBOL_BITS;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int ROW_DEPTH   = 1 << STATE_BITS;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = STACK_AW + 1;
    localparam int PEND_AW     = $clog2(PENDING_DEPTH);
    localparam int PEND_CW     = $clog2(PENDING_DEPTH + 1);
    localparam int POP_W       = 4;
    localparam int OPCODE_W    = 3;
    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 8;
    localparam int CAUSE_W     = 3;
    localparam int LIMIT_W     = 7;
    localparam int STEP_W      = 6;
    localparam int STEP_MAX    = (1 << STEP_W) - 1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TOKEN   = 3'd0,
        OP_SHIFT   = 3'd1,
        OP_GOTO    = 3'd2,
        OP_REDUCE  = 3'd3,
        OP_RESTART = 3'd4
    } opcode_t;

    localparam logic [KIND_W-1:0] ACT_SHIFT  = 3'd0;
    localparam logic [KIND_W-1:0] ACT_GOTO   = 3'd1;
    localparam logic [KIND_W-1:0] ACT_REDUCE = 3'd2;
    localparam logic [KIND_W-1:0] ACT_ACCEPT = 3'd3;
    localparam logic [KIND_W-1:0] ACT_ERROR  = 3'd4;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_ENTRY  = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_UNDERFLOW = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_STEP_LIM  = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_HALTED    = 3'd5;

    typedef struct packed {
        logic                  valid;
        logic                  accept;
        logic [STATE_BITS-1:0] target;
    } shift_entry_t;

    typedef struct packed {
        logic                  valid;
        logic [STATE_BITS-1:0] target;
    } goto_entry_t;

    typedef struct packed {
        logic                   valid;
        logic [POP_W-1:0]       pops;
        logic [SYMBOL_BITS-1:0] nonterm;
    } reduce_entry_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_POP   = 7'b0010000,
        S_HALT  = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

endpackage

// ===== rtl/lr0p_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lr0p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lr0_table_driven_parser_top.sv =====
// LR(0) shift-reduce parser engine: table loading, token runs, result output.
// Flow: writes, restart and ignored opcodes are taken in S_IDLE; a lookup action passes
// S_LOOK (read) and S_EVAL (decide), and S_POP too when a reduce pops to a state read from
// the stack memory; a step-limit error is raised in S_LOOK and a token while halted is
// answered in S_HALT. A token keeps in_ready low through its results and out_ready stalls.
// Reset: a pass over every table address clears the tables, then state 0, nothing pending, limit 64.
module lr0_table_driven_parser_top
    import lr0p_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [LIMIT_W-1:0]     cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [SYMBOL_BITS-1:0] symbol,
    input  logic [STATE_BITS-1:0]  row_state,
    input  logic [STATE_BITS-1:0]  target_state,
    input  logic                   accept_mark,
    input  logic [POP_W-1:0]       pop_count,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [KIND_W-1:0]      action_kind,
    output logic [VALUE_W-1:0]     action_value,
    output logic [CAUSE_W-1:0]     error_cause,
    output logic                   last_of_run
);

    state_t                 state_reg, state_next;
    logic [TABLE_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [LIMIT_W-1:0]     step_limit_reg;
    logic [SYMBOL_BITS-1:0] tok_sym_reg, tok_sym_next;
    logic [STATE_BITS-1:0]  top_reg, top_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [PEND_CW-1:0]     pend_cnt_reg, pend_cnt_next;
    logic [SYMBOL_BITS-1:0] pend_reg [PENDING_DEPTH];
    logic                   halted_reg, halted_next;
    logic [STEP_W-1:0]      steps_reg, steps_next;
    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [CAUSE_W-1:0]     cause_reg;
    logic                   last_reg;

    logic                   in_accept;
    logic                   out_free;
    logic                   clearing;
    logic [STEP_W-1:0]      lim;
    logic [PEND_AW-1:0]     pend_idx;
    logic [SYMBOL_BITS-1:0] cur_sym;
    logic [TABLE_AW-1:0]    look_addr;
    logic [TABLE_AW-1:0]    tbl_waddr;
    logic [STATE_BITS-1:0]  row_waddr;

    logic                   shift_we, goto_we, reduce_we, tbl_re;
    shift_entry_t           shift_wdata, shift_rd;
    goto_entry_t            goto_wdata, goto_rd;
    reduce_entry_t          reduce_wdata, reduce_rd;

    logic                   push_en, pop_re;
    logic [STATE_BITS-1:0]  push_state;
    logic [STACK_AW-1:0]    pop_addr;
    logic [STATE_BITS-1:0]  stack_rdata;
    logic [DEPTH_W-1:0]     reduced_depth;

    logic                   pend_we;
    logic [PEND_AW-1:0]     pend_widx;

    logic                   emit_en;
    logic [KIND_W-1:0]      emit_kind;
    logic [VALUE_W-1:0]     emit_value;
    logic [CAUSE_W-1:0]     emit_cause;
    logic                   emit_last;

    assign clearing  = (state_reg == S_CLEAR);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;

    always_comb
    begin
        if (step_limit_reg == '0)
        begin
            lim = STEP_W'(1);
        end
        else if (step_limit_reg > LIMIT_W'(STEP_MAX))
        begin
            lim = STEP_W'(STEP_MAX);
        end
        else
        begin
            lim = step_limit_reg[STEP_W-1:0];
        end
    end

    assign pend_idx  = PEND_AW'(pend_cnt_reg - PEND_CW'(1));
    assign cur_sym   = (pend_cnt_reg != '0) ? pend_reg[pend_idx] : tok_sym_reg;
    assign look_addr = {top_reg, cur_sym};

    assign tbl_waddr = clearing ? clr_addr_reg : {row_state, symbol};
    assign row_waddr = clearing ? clr_addr_reg[STATE_BITS-1:0] : row_state;

    assign shift_we  = clearing | (in_accept & (opcode == OP_SHIFT));
    assign goto_we   = clearing | (in_accept & (opcode == OP_GOTO));
    assign reduce_we = clearing | (in_accept & (opcode == OP_REDUCE));

    always_comb
    begin
        shift_wdata  = '0;
        goto_wdata   = '0;
        reduce_wdata = '0;
        if (!clearing)
        begin
            shift_wdata.valid    = 1'b1;
            shift_wdata.accept   = accept_mark;
            shift_wdata.target   = accept_mark ? '0 : target_state;
            goto_wdata.valid     = 1'b1;
            goto_wdata.target    = target_state;
            reduce_wdata.valid   = 1'b1;
            reduce_wdata.pops    = pop_count;
            reduce_wdata.nonterm = symbol;
        end
    end

    lr0p_ram #(.WIDTH($bits(shift_entry_t)), .DEPTH(TABLE_DEPTH)) u_shift_ram (
        .clk   (clk),
        .we    (shift_we),
        .waddr (tbl_waddr),
        .wdata (shift_wdata),
        .re    (tbl_re),
        .raddr (look_addr),
        .rdata (shift_rd)
    );

    lr0p_ram #(.WIDTH($bits(goto_entry_t)), .DEPTH(TABLE_DEPTH)) u_goto_ram (
        .clk   (clk),
        .we    (goto_we),
        .waddr (tbl_waddr),
        .wdata (goto_wdata),
        .re    (tbl_re),
        .raddr (look_addr),
        .rdata (goto_rd)
    );

    lr0p_ram #(.WIDTH($bits(reduce_entry_t)), .DEPTH(ROW_DEPTH)) u_reduce_ram (
        .clk   (clk),
        .we    (reduce_we),
        .waddr (row_waddr),
        .wdata (reduce_wdata),
        .re    (tbl_re),
        .raddr (top_reg),
        .rdata (reduce_rd)
    );

    lr0p_ram #(.WIDTH(STATE_BITS), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (push_en),
        .waddr (depth_reg[STACK_AW-1:0]),
        .wdata (push_state),
        .re    (pop_re),
        .raddr (pop_addr),
        .rdata (stack_rdata)
    );

    assign push_state    = shift_rd.valid ? shift_rd.target : goto_rd.target;
    assign reduced_depth = depth_reg - DEPTH_W'(reduce_rd.pops);
    assign pop_addr      = STACK_AW'(reduced_depth - DEPTH_W'(1));
    assign pend_widx     = pend_cnt_reg[PEND_AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        tok_sym_next  = tok_sym_reg;
        top_next      = top_reg;
        depth_next    = depth_reg;
        pend_cnt_next = pend_cnt_reg;
        halted_next   = halted_reg;
        steps_next    = steps_reg;
        tbl_re        = 1'b0;
        push_en       = 1'b0;
        pop_re        = 1'b0;
        pend_we       = 1'b0;
        emit_en       = 1'b0;
        emit_kind     = ACT_ERROR;
        emit_value    = '0;
        emit_cause    = CAUSE_NONE;
        emit_last     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + TABLE_AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (opcode)
                        OP_TOKEN:
                        begin
                            tok_sym_next = symbol;
                            steps_next   = '0;
                            state_next   = halted_reg ? S_HALT : S_LOOK;
                        end
                        OP_RESTART:
                        begin
                            top_next      = '0;
                            depth_next    = DEPTH_W'(1);
                            pend_cnt_next = '0;
                            halted_next   = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (steps_reg >= lim)
                begin
                    if (out_free)
                    begin
                        emit_en     = 1'b1;
                        emit_cause  = CAUSE_STEP_LIM;
                        emit_last   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    tbl_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    steps_next = steps_reg + STEP_W'(1);
                    if (shift_rd.valid && shift_rd.accept)
                    begin
                        emit_kind   = ACT_ACCEPT;
                        emit_last   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (shift_rd.valid || goto_rd.valid)
                    begin
                        if (depth_reg >= DEPTH_W'(STACK_DEPTH))
                        begin
                            emit_cause  = CAUSE_OVERFLOW;
                            emit_last   = 1'b1;
                            halted_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            push_en    = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                            top_next   = push_state;
                            emit_kind  = shift_rd.valid ? ACT_SHIFT : ACT_GOTO;
                            emit_value = VALUE_W'(push_state);
                            if (pend_cnt_reg != '0)
                            begin
                                pend_cnt_next = pend_cnt_reg - PEND_CW'(1);
                                state_next    = S_LOOK;
                            end
                            else
                            begin
                                emit_last  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                    end
                    else if (!reduce_rd.valid)
                    begin
                        emit_cause  = CAUSE_NO_ENTRY;
                        emit_last   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (DEPTH_W'(reduce_rd.pops) >= depth_reg)
                    begin
                        emit_cause  = CAUSE_UNDERFLOW;
                        emit_last   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (pend_cnt_reg >= PEND_CW'(PENDING_DEPTH))
                    begin
                        emit_cause  = CAUSE_OVERFLOW;
                        emit_last   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        pend_we       = 1'b1;
                        pend_cnt_next = pend_cnt_reg + PEND_CW'(1);
                        depth_next    = reduced_depth;
                        emit_kind     = ACT_REDUCE;
                        emit_value    = VALUE_W'(reduce_rd.pops);
                        if (reduce_rd.pops == '0)
                        begin
                            state_next = S_LOOK;
                        end
                        else if (reduced_depth == DEPTH_W'(1))
                        begin
                            top_next   = '0;
                            state_next = S_LOOK;
                        end
                        else
                        begin
                            pop_re     = 1'b1;
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_POP:
            begin
                top_next   = stack_rdata;
                state_next = S_LOOK;
            end
            S_HALT:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_cause = CAUSE_HALTED;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit_en | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            step_limit_reg <= LIMIT_RESET;
            top_reg        <= '0;
            depth_reg      <= DEPTH_W'(1);
            pend_cnt_reg   <= '0;
            halted_reg     <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            top_reg       <= top_next;
            depth_reg     <= depth_next;
            pend_cnt_reg  <= pend_cnt_next;
            halted_reg    <= halted_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                step_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_sym_reg <= tok_sym_next;
        if (pend_we)
        begin
            pend_reg[pend_widx] <= reduce_rd.nonterm;
        end
        if (emit_en)
        begin
            kind_reg  <= emit_kind;
            value_reg <= emit_value;
            cause_reg <= emit_cause;
            last_reg  <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action_kind  = kind_reg;
    assign action_value = value_reg;
    assign error_cause  = cause_reg;
    assign last_of_run  = last_reg;

endmodule

// ===== rtl/lr0p_checker.sv =====
// Port-level assertions for the LR(0) parser engine, bound to the top level.
module lr0p_checker
    import lr0p_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [KIND_W-1:0]   action_kind,
    input logic [VALUE_W-1:0]  action_value,
    input logic [CAUSE_W-1:0]  error_cause,
    input logic                last_of_run
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action_kind)
            && $stable(action_value) && $stable(error_cause) && $stable(last_of_run))
        else $error("stalled result changed");

    a_cause_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action_kind != ACT_ERROR |-> error_cause == CAUSE_NONE)
        else $error("cause set on a non-error result");

    a_terminal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action_kind == ACT_ACCEPT || action_kind == ACT_ERROR)
            |-> last_of_run)
        else $error("accept or error not marked last");

    a_terminal_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action_kind == ACT_ACCEPT || action_kind == ACT_ERROR)
            |-> action_value == '0)
        else $error("accept or error with nonzero value");

    a_error_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action_kind == ACT_ERROR |-> error_cause != CAUSE_NONE)
        else $error("error result without cause");

endmodule

bind lr0_table_driven_parser_top lr0p_checker u_lr0p_checker (.*);
